>>> rtl/bnsb_pkg.sv
`timescale 1ns / 1ps

package bnsb_pkg;

  // Widths fixed by the transaction fields.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned WIDX_W = 4;
  localparam int unsigned BIT_W  = 6;               // bit offset inside one word
  localparam int unsigned WSEL_W = POS_W - BIT_W;   // word number of a bit position

  // The word index port reaches this many words at most.
  localparam int unsigned MAX_WORDS     = 2 ** WIDX_W;
  localparam int unsigned NUM_WORDS_DEF = 16;

  // Trailing-zero count by halving: 32, 16, 8, 4, 2, 1.
  localparam int unsigned CTZ_STEPS = 6;
  localparam int unsigned STEP_W    = 3;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic             done;
    logic [BIT_W-1:0] count;
  } ctz_status_t;

endpackage

>>> rtl/bitmap_next_set_bit_search_core.sv
`timescale 1ns / 1ps

// Next-set-bit search over a bitmap of 64-bit words. A transaction with mode_i low
// stores word_data_i into word word_index_i in the accepting cycle and returns nothing;
// an index at or beyond NUM_WORDS is dropped. A transaction with mode_i high returns,
// exactly once, the lowest set bit at or above start_bit_i and below search_limit_i,
// or search_limit_i with none_found_o high when there is none. Results appear for a
// single cycle with result_valid_o and cannot be held off, so capture them when the
// strobe is seen. An empty range (start at or above limit) is answered from the idle
// state. Otherwise the sequencer reads one bitmap word per cycle, starting at the word
// that holds the start bit and reading k words in all, with k between 1 and 32. On a
// hit the word goes to the trailing-zero unit for its six halving steps, and its finish
// flag then leads to the result. A miss is reported once the word that holds the last
// bit below the limit has been read. busy is high while a search runs. The bitmap is
// zero after reset.
module bitmap_next_set_bit_search_core
  import bnsb_pkg::*;
#(
  parameter int unsigned NUM_WORDS = NUM_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              mode_i,
  input  logic [WIDX_W-1:0] word_index_i,
  input  logic [WORD_W-1:0] word_data_i,
  input  logic [POS_W-1:0]  start_bit_i,
  input  logic [POS_W-1:0]  search_limit_i,
  output logic              result_valid_o,
  output logic [POS_W-1:0]  bit_position_o,
  output logic              none_found_o
);

  // Only the first MAX_WORDS words can ever be written; anything above reads as zero
  // and needs no storage.
  localparam int unsigned DEPTH = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    CTZ
  } state_e;

  state_e             state_q;
  logic [WSEL_W-1:0]  scan_w_q;
  logic [WSEL_W-1:0]  last_q;
  logic               first_q;
  logic [POS_W-1:0]   start_q;
  logic [POS_W-1:0]   lim_q;
  logic [BIT_W-1:0]   lim_lo_q;

  logic [WORD_W-1:0]  bitmap_q [DEPTH];

  logic               accept;
  logic               wr_en;
  logic [POS_W-1:0]   lim_m1;
  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  first_mask;
  logic [WORD_W-1:0]  last_mask;
  logic [WORD_W-1:0]  masked_word;
  logic               hit;
  ctz_status_t        ctz_st;

  assign busy   = (state_q != IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (mode_i == MODE_WRITE)
                  && ({1'b0, word_index_i} < (WIDX_W+1)'(DEPTH));
  assign lim_m1 = search_limit_i - POS_W'(1);

  // Bitmap storage; reset clears every word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(DEPTH); i++) begin
        bitmap_q[i] <= '0;
      end
    end else if (wr_en) begin
      bitmap_q[word_index_i[IDX_W-1:0]] <= word_data_i;
    end
  end

  // Word under scan, with the bits below the start cut off in the first word and the
  // bits at or above the limit cut off in the last word.
  assign rd_word = ({1'b0, scan_w_q} < (WSEL_W+1)'(DEPTH)) ?
                   bitmap_q[scan_w_q[IDX_W-1:0]] : '0;
  assign first_mask  = first_q ? ({WORD_W{1'b1}} << start_q[BIT_W-1:0])
                               : {WORD_W{1'b1}};
  assign last_mask   = (scan_w_q == last_q) ?
                       ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - lim_lo_q))
                       : {WORD_W{1'b1}};
  assign masked_word = rd_word & first_mask & last_mask;
  assign hit         = (state_q == SCAN) && (masked_word != '0);

  bnsb_ctz u_ctz (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (hit),
    .word_i   (masked_word),
    .status_o (ctz_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= IDLE;
      scan_w_q       <= '0;
      last_q         <= '0;
      first_q        <= 1'b0;
      start_q        <= '0;
      lim_q          <= '0;
      lim_lo_q       <= '0;
      result_valid_o <= 1'b0;
      bit_position_o <= '0;
      none_found_o   <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        IDLE: begin
          if (start && (mode_i == MODE_SEARCH)) begin
            start_q  <= start_bit_i;
            lim_q    <= search_limit_i;
            lim_lo_q <= lim_m1[BIT_W-1:0];
            scan_w_q <= start_bit_i[POS_W-1:BIT_W];
            last_q   <= lim_m1[POS_W-1:BIT_W];
            first_q  <= 1'b1;
            if (start_bit_i >= search_limit_i) begin
              result_valid_o <= 1'b1;
              bit_position_o <= search_limit_i;
              none_found_o   <= 1'b1;
            end else begin
              state_q <= SCAN;
            end
          end
        end
        SCAN: begin
          first_q <= 1'b0;
          if (hit) begin
            state_q <= CTZ;
          end else if (scan_w_q == last_q) begin
            result_valid_o <= 1'b1;
            bit_position_o <= lim_q;
            none_found_o   <= 1'b1;
            state_q        <= IDLE;
          end else begin
            scan_w_q <= scan_w_q + WSEL_W'(1);
          end
        end
        CTZ: begin
          if (ctz_st.done) begin
            result_valid_o <= 1'b1;
            bit_position_o <= {scan_w_q, ctz_st.count};
            none_found_o   <= 1'b0;
            state_q        <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A found bit always lies inside the searched range.
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !none_found_o) |->
      (bit_position_o >= start_q) && (bit_position_o < lim_q))
    else $error("found bit position outside the searched range");

  // The trailing-zero unit only finishes while the sequencer waits for it.
  a_ctz_done_in_ctz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctz_st.done |-> (state_q == CTZ))
    else $error("trailing-zero result outside the count state");

  // The scan never runs past the word that holds the last bit below the limit.
  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCAN) |-> (scan_w_q <= last_q))
    else $error("scan passed the last word of the range");
`endif

endmodule

>>> rtl/bnsb_ctz.sv
`timescale 1ns / 1ps

// Counts the trailing zeros of a nonzero word, one halving step per cycle.
module bnsb_ctz
  import bnsb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [WORD_W-1:0] word_i,
  output ctz_status_t       status_o
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CTZ_STEPS - 1);

  logic [WORD_W-1:0] v_q;
  logic [BIT_W-1:0]  n_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q;
  logic              done_q;

  logic [BIT_W:0]    shamt;
  logic [WORD_W-1:0] low_mask;
  logic              low_zero;

  // The shared step: test the low half of the live window, and drop it when it is zero.
  assign shamt    = (BIT_W+1)'((BIT_W+1)'(WORD_W / 2) >> step_q);
  assign low_mask = {WORD_W{1'b1}} >> ((BIT_W+1)'(WORD_W) - shamt);
  assign low_zero = (v_q & low_mask) == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (load_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        if (step_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q <= word_i;
      n_q <= '0;
    end else if (run_q && low_zero) begin
      v_q <= v_q >> shamt;
      n_q <= n_q + shamt[BIT_W-1:0];
    end
  end

  assign status_o.done  = done_q;
  assign status_o.count = n_q;

endmodule

>>> verif/bitmap_next_set_bit_search_core_tb.sv
`timescale 1ns / 1ps

// The testbench drives write and search transactions into the bitmap search core. It keeps
// its own copy of the bitmap and from it works out each expected result not typed by hand.
// The run starts with a short directed table and then sends random traffic in bursts with
// random gaps. Each result strobe is compared with the oldest pending expectation.
module bitmap_next_set_bit_search_core_tb;
  import bnsb_pkg::*;

  localparam int unsigned NUM_WORDS    = NUM_WORDS_DEF;
  localparam int unsigned MAP_BITS     = NUM_WORDS * WORD_W;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 925;
  // The longest search reads every word and then runs the halving steps.
  // The drain time after the last result covers that with some margin.
  localparam int unsigned DRAIN_CYCLES = 80;
  // The longest quiet stretch in a correct run is a sender gap plus one full search.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS  = 50;

  // One search outcome: the bit found (or the limit) and the none-found flag.
  typedef struct {
    logic [POS_W-1:0] pos;
    logic             none;
  } hit_t;

  // One stimulus row. When typed is set, hit holds the expected result read off by hand.
  // Otherwise the expected result comes from the bitmap predictor.
  typedef struct {
    logic              mode;
    logic [WIDX_W-1:0] idx;
    logic [WORD_W-1:0] data;
    logic [POS_W-1:0]  from_bit;
    logic [POS_W-1:0]  limit;
    bit                typed;
    hit_t              hit;
  } stim_row_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic              mode_i         = MODE_WRITE;
  logic [WIDX_W-1:0] word_index_i   = '0;
  logic [WORD_W-1:0] word_data_i    = '0;
  logic [POS_W-1:0]  start_bit_i    = '0;
  logic [POS_W-1:0]  search_limit_i = '0;
  logic              result_valid_o;
  logic [POS_W-1:0]  bit_position_o;
  logic              none_found_o;

  // These travel alongside each transaction so that the monitor knows whether the row
  // carries a hand-typed expectation.
  bit                row_typed = 1'b0;
  logic [POS_W-1:0]  row_pos   = '0;
  logic              row_none  = 1'b0;

  // The testbench copy of the bitmap. It is updated when a write transaction is accepted.
  logic [WORD_W-1:0] bitmap_model [NUM_WORDS];
  hit_t              expected_hits [$];
  int unsigned       mismatches  = 0;
  int unsigned       idle_cycles = 0;

  bitmap_next_set_bit_search_core #(
    .NUM_WORDS(NUM_WORDS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .word_index_i  (word_index_i),
    .word_data_i   (word_data_i),
    .start_bit_i   (start_bit_i),
    .search_limit_i(search_limit_i),
    .result_valid_o(result_valid_o),
    .bit_position_o(bit_position_o),
    .none_found_o  (none_found_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Scans the bitmap copy bit by bit from the start position up to, but not including,
  // the limit. Positions past the end of the bitmap read as zero.
  function automatic hit_t find_next_set(input logic [POS_W-1:0] from_bit,
                                         input logic [POS_W-1:0] limit);
    hit_t        r;
    int unsigned p;
    r.pos  = limit;
    r.none = 1'b1;
    for (p = from_bit; p < limit; p++) begin
      if (r.none && p < MAP_BITS && bitmap_model[p / WORD_W][p % WORD_W]) begin
        r.pos  = p[POS_W-1:0];
        r.none = 1'b0;
      end
    end
    return r;
  endfunction

  // The monitor samples everything at the rising edge, before the block or the driver
  // update anything in that time step. A transaction is accepted when start is high and
  // busy is low. A result is accepted whenever the strobe is high.
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (result_valid_o) begin
        idle_cycles = 0;
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no search pending",
                                    bit_position_o, none_found_o));
        end else begin
          want = expected_hits.pop_front();
          if (bit_position_o !== want.pos) begin
            report_mismatch($sformatf("bit_position %0d, expected %0d",
                                      bit_position_o, want.pos));
          end
          if (none_found_o !== want.none) begin
            report_mismatch($sformatf("none_found %0b, expected %0b",
                                      none_found_o, want.none));
          end
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        if (mode_i == MODE_WRITE) begin
          // A write past the end of the bitmap is dropped by the block.
          if (word_index_i < NUM_WORDS) begin
            bitmap_model[word_index_i] = word_data_i;
          end
        end else begin
          if (row_typed) begin
            want.pos  = row_pos;
            want.none = row_none;
          end else begin
            want = find_next_set(start_bit_i, search_limit_i);
          end
          expected_hits.push_back(want);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Presents one transaction and returns at the edge where the block accepts it. It must
  // be called right after a rising edge.
  task automatic send_item(input stim_row_t r);
    mode_i         <= r.mode;
    word_index_i   <= r.idx;
    word_data_i    <= r.data;
    start_bit_i    <= r.from_bit;
    search_limit_i <= r.limit;
    row_typed      <= r.typed;
    row_pos        <= r.hit.pos;
    row_none       <= r.hit.none;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds the sender off until every pending search has returned. The queue is checked at
  // the falling edge, away from the monitor's updates.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_hits.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic stim_row_t write_row(input int unsigned idx,
                                          input logic [WORD_W-1:0] data);
    stim_row_t r;
    r.mode     = MODE_WRITE;
    r.idx      = idx[WIDX_W-1:0];
    r.data     = data;
    // The position fields are ignored on a write, so they carry values that would matter
    // on a search.
    r.from_bit = POS_W'(MAP_BITS);
    r.limit    = '0;
    r.typed    = 1'b0;
    r.hit.pos  = '0;
    r.hit.none = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t search_row(input int unsigned from_bit,
                                           input int unsigned limit, input bit typed,
                                           input int unsigned pos, input logic none);
    stim_row_t r;
    r.mode     = MODE_SEARCH;
    // The index and data fields are ignored on a search.
    r.idx      = '1;
    r.data     = '1;
    r.from_bit = from_bit[POS_W-1:0];
    r.limit    = limit[POS_W-1:0];
    r.typed    = typed;
    r.hit.pos  = pos[POS_W-1:0];
    r.hit.none = none;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 6))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(0, WORD_W - 1);
      3:       w = {$urandom, $urandom};
      4:       w = {$urandom, 32'h0};   // makes the upper halving steps do the work
      default: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Random transactions. Searches outnumber writes since only they give results. Half of
  // the searches cover narrow windows so that hits and misses both occur often.
  function automatic stim_row_t random_row();
    stim_row_t   r;
    int unsigned from_bit;
    int unsigned limit;
    if ($urandom_range(0, 99) < 40) begin
      r           = write_row($urandom_range(0, NUM_WORDS - 1), random_word());
      r.from_bit  = POS_W'($urandom_range(0, MAP_BITS));
      r.limit     = POS_W'($urandom_range(0, MAP_BITS));
    end else begin
      from_bit = $urandom_range(0, MAP_BITS);
      case ($urandom_range(0, 5))
        0: begin
          from_bit = 0;
          limit    = MAP_BITS;
        end
        1, 2: begin
          limit = from_bit + $urandom_range(0, 96);
          if (limit > MAP_BITS) limit = MAP_BITS;
        end
        3:       limit = $urandom_range(0, MAP_BITS);
        4:       limit = MAP_BITS;
        default: begin
          from_bit = MAP_BITS - $urandom_range(0, 8);
          limit    = MAP_BITS - $urandom_range(0, 4);
        end
      endcase
      r      = search_row(from_bit, limit, 1'b0, 0, 1'b0);
      r.idx  = WIDX_W'($urandom_range(0, NUM_WORDS - 1));
      r.data = {$urandom, $urandom};
    end
    return r;
  endfunction

  initial begin
    stim_row_t   directed_rows [$];
    int unsigned burst_left;
    int unsigned w;
    int unsigned n;

    for (w = 0; w < NUM_WORDS; w++) begin
      bitmap_model[w] = '0;
    end

    // The bitmap is empty after reset, so the first searches can only miss. The empty
    // range rows check that a start at or above the limit returns the limit.
    directed_rows.push_back(search_row(0, MAP_BITS, 1'b1, MAP_BITS, 1'b1));
    directed_rows.push_back(search_row(MAP_BITS, MAP_BITS, 1'b1, MAP_BITS, 1'b1));
    directed_rows.push_back(search_row(5, 0, 1'b1, 0, 1'b1));
    directed_rows.push_back(search_row(0, 0, 1'b1, 0, 1'b1));
    // Lowest and highest bit of the whole bitmap.
    directed_rows.push_back(write_row(0, 64'h1));
    directed_rows.push_back(search_row(0, MAP_BITS, 1'b1, 0, 1'b0));
    directed_rows.push_back(search_row(1, MAP_BITS, 1'b1, MAP_BITS, 1'b1));
    directed_rows.push_back(write_row(NUM_WORDS - 1, 64'h8000_0000_0000_0000));
    directed_rows.push_back(search_row(1, MAP_BITS, 1'b1, MAP_BITS - 1, 1'b0));
    directed_rows.push_back(search_row(1, MAP_BITS - 1, 1'b1, MAP_BITS - 1, 1'b1));
    directed_rows.push_back(search_row(MAP_BITS - 1, MAP_BITS, 1'b1, MAP_BITS - 1, 1'b0));
    directed_rows.push_back(search_row(0, 1, 1'b1, 0, 1'b0));
    // A full word in the middle: the start bit masks the low part, the limit the top.
    directed_rows.push_back(write_row(7, '1));
    directed_rows.push_back(search_row(100, MAP_BITS, 1'b1, 448, 1'b0));
    directed_rows.push_back(search_row(500, 511, 1'b1, 500, 1'b0));
    directed_rows.push_back(search_row(511, 512, 1'b1, 511, 1'b0));
    directed_rows.push_back(write_row(3, 64'h0000_0001_0000_0000));
    directed_rows.push_back(search_row(1, MAP_BITS, 1'b1, 224, 1'b0));
    // From here on the predictor supplies the expected results.
    directed_rows.push_back(write_row(9, 64'hA5A5_0000_0000_0000));
    directed_rows.push_back(search_row(580, MAP_BITS, 1'b0, 0, 1'b0));
    directed_rows.push_back(write_row(7, '0));
    directed_rows.push_back(search_row(300, MAP_BITS, 1'b0, 0, 1'b0));
    directed_rows.push_back(write_row(NUM_WORDS - 1, '1));
    directed_rows.push_back(write_row(0, '0));
    directed_rows.push_back(search_row(2, 1000, 1'b0, 0, 1'b0));
    directed_rows.push_back(search_row(1000, MAP_BITS, 1'b0, 0, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
    end

    // Random traffic comes in bursts of back-to-back transactions with quiet gaps in
    // between. Now and then, and once in the middle, the sender waits for all results.
    wait_drained();
    burst_left = $urandom_range(1, 24);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 63) == 0) begin
        wait_drained();
      end
      send_item(random_row());
      burst_left--;
      if (burst_left == 0) begin
        pause($urandom_range(1, 10));
        burst_left = $urandom_range(1, 24);
      end
    end

    // Any result that shows up during the drain time has no expectation and fails.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
